[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL: clocked, reset-qualified properties.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

[rtl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared widths, thread state codes and helpers for the thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MAX_THREADS = 8;
  localparam int TID_W       = $clog2(MAX_THREADS);
  localparam int CUR_W       = $clog2(MAX_THREADS + 1);
  localparam int CNT_W       = CUR_W;
  localparam int ACT_W       = 4;
  localparam int TICK_W      = 16;
  localparam int SEM_W       = 8;
  localparam int CFG_W       = 7;
  localparam int OUT_TID_W   = 4;

  localparam logic signed [SEM_W-1:0] SEM_TOP   = 8'sd127;
  localparam logic signed [SEM_W-1:0] SEM_FLOOR = SEM_W'(-MAX_THREADS);

  typedef enum logic [2:0] {
    ST_ABSENT   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_WAITING  = 3'd4
  } tstate_t;

  // write request into the thread table
  typedef struct packed {
    logic               st_en;
    logic               cnt_en;
    logic [TID_W-1:0]   idx;
    tstate_t            st;
    logic [TICK_W-1:0]  cnt;
  } tt_wr_t;

  function automatic logic [TID_W-1:0] ring_next(input logic [TID_W-1:0] p);
    return (p == TID_W'(MAX_THREADS - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

[rtl/rrts_ram.sv]
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rrts_thread_table.sv]
// ----------------------------------------------------------------------------
// rrts_thread_table
// Per-thread state and sleep counter, one read and one write slot per cycle.
// ----------------------------------------------------------------------------
module rrts_thread_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rrts_pkg::TID_W-1:0]   rd_idx,
  output rrts_pkg::tstate_t            rd_state,
  output logic [rrts_pkg::TICK_W-1:0]  rd_count,
  input  rrts_pkg::tt_wr_t             wr
);

  rrts_pkg::tstate_t            state_r [rrts_pkg::MAX_THREADS];
  logic [rrts_pkg::TICK_W-1:0]  count_r [rrts_pkg::MAX_THREADS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rrts_pkg::MAX_THREADS; i++) begin
        state_r[i] <= rrts_pkg::ST_ABSENT;
        count_r[i] <= '0;
      end
    end else begin
      if (wr.st_en) begin
        state_r[wr.idx] <= wr.st;
      end
      if (wr.cnt_en) begin
        count_r[wr.idx] <= wr.cnt;
      end
    end
  end

  assign rd_state = state_r[rd_idx];
  assign rd_count = count_r[rd_idx];

endmodule

[rtl/round_robin_thread_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Thread-state scheduler with round-robin pick, one mutex and one semaphore.
// ----------------------------------------------------------------------------
// One item is taken at a time and each gives one result. Unlock and signal
// with a waiter add a wait ring step, and a signal swap then also runs the
// switch states. Yield and one-tick sleep scan the thread table one slot a
// cycle; a tick first walks every slot through the shared sleep decrementer.
// A finished result waits in the output register while the next item is
// taken. Wait rings sit in small RAMs with registered read data.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module round_robin_thread_scheduler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rrts_pkg::ACT_W-1:0]          in_action,
  input  logic [rrts_pkg::TICK_W-1:0]         in_sleep_ticks,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rrts_pkg::OUT_TID_W-1:0]      out_running_thread,
  output logic [rrts_pkg::OUT_TID_W-1:0]      out_previous_thread,
  output logic                                out_switched,
  output logic                                out_mutex_is_free,
  output logic signed [rrts_pkg::SEM_W-1:0]   out_sem_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrts_pkg::CFG_W-1:0]          cfg_sem_initial
);

  typedef enum logic [3:0] {
    ACT_CREATE   = 4'd0,
    ACT_TICK     = 4'd1,
    ACT_SLEEP    = 4'd2,
    ACT_YIELD    = 4'd3,
    ACT_LOCK     = 4'd4,
    ACT_UNLOCK   = 4'd5,
    ACT_SEM_WAIT = 4'd6,
    ACT_SIGNAL   = 4'd7,
    ACT_SWAP     = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_CNT, S_SCAN, S_SW1, S_SW2, S_MQ, S_SQ
  } seq_state_t;

  seq_state_t                           state_r;
  logic                                 done_r;
  logic [rrts_pkg::ACT_W-1:0]           act_r;
  logic [rrts_pkg::TICK_W-1:0]          ticks_r;
  logic [rrts_pkg::CUR_W-1:0]           cur_r;
  logic [rrts_pkg::CUR_W-1:0]           prev_r;
  logic [rrts_pkg::TID_W-1:0]           idx_r;
  logic                                 sw_r;
  logic                                 mfree_r;
  logic [rrts_pkg::TID_W-1:0]           mhead_r;
  logic [rrts_pkg::TID_W-1:0]           mtail_r;
  logic [rrts_pkg::CNT_W-1:0]           mwait_r;
  logic signed [rrts_pkg::SEM_W-1:0]    sem_r;
  logic [rrts_pkg::TID_W-1:0]           shead_r;
  logic [rrts_pkg::TID_W-1:0]           stail_r;
  logic                                 out_valid_r;
  logic [rrts_pkg::OUT_TID_W-1:0]       out_run_r;
  logic [rrts_pkg::OUT_TID_W-1:0]       out_prev_r;
  logic                                 out_sw_r;
  logic                                 out_mfree_r;
  logic signed [rrts_pkg::SEM_W-1:0]    out_sem_r;

  logic [rrts_pkg::TID_W-1:0]           cur_idx;
  logic                                 cur_valid;
  logic                                 one_tick;
  logic                                 lock_blocks;
  logic                                 wait_blocks;
  logic [rrts_pkg::TID_W-1:0]           tt_rd_idx;
  rrts_pkg::tstate_t                    tt_rd_state;
  logic [rrts_pkg::TICK_W-1:0]          tt_rd_count;
  rrts_pkg::tt_wr_t                     tt_wr;
  logic                                 mq_we;
  logic                                 sq_we;
  logic [rrts_pkg::TID_W-1:0]           mq_rdata;
  logic [rrts_pkg::TID_W-1:0]           sq_rdata;
  logic [rrts_pkg::CUR_W-1:0]           cur_eff;

  assign cur_idx     = cur_r[rrts_pkg::TID_W-1:0];
  assign cur_valid   = cur_r < rrts_pkg::CUR_W'(rrts_pkg::MAX_THREADS);
  assign one_tick    = ticks_r == rrts_pkg::TICK_W'(1);
  assign lock_blocks = !mfree_r && cur_valid
                       && (mwait_r < rrts_pkg::CNT_W'(rrts_pkg::MAX_THREADS));
  assign wait_blocks = !(sem_r > 0) && cur_valid && (sem_r > rrts_pkg::SEM_FLOOR);
  assign cur_eff     = cur_valid ? cur_r : '0;

  assign in_stall  = (state_r != S_IDLE) || done_r || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE) && !done_r;

  // thread table port steering
  always_comb begin
    tt_rd_idx = idx_r;
    tt_wr     = '0;
    tt_wr.idx = cur_idx;
    tt_wr.st  = rrts_pkg::ST_READY;
    tt_wr.cnt = ticks_r;
    mq_we     = 1'b0;
    sq_we     = 1'b0;
    case (state_r)
      S_EXEC: begin
        case (act_r)
          ACT_CREATE: begin
            tt_wr.st_en = cur_valid;
          end
          ACT_SLEEP: begin
            if (!one_tick && cur_valid) begin
              tt_wr.st_en  = 1'b1;
              tt_wr.cnt_en = 1'b1;
              tt_wr.st     = rrts_pkg::ST_SLEEPING;
            end
          end
          ACT_LOCK: begin
            if (lock_blocks) begin
              tt_wr.st_en = 1'b1;
              tt_wr.st    = rrts_pkg::ST_WAITING;
              mq_we       = 1'b1;
            end
          end
          ACT_SEM_WAIT: begin
            if (wait_blocks) begin
              tt_wr.st_en = 1'b1;
              tt_wr.st    = rrts_pkg::ST_WAITING;
              sq_we       = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_CNT: begin
        tt_wr.idx = idx_r;
        if (tt_rd_state == rrts_pkg::ST_SLEEPING) begin
          if (tt_rd_count == '0) begin
            tt_wr.st_en = 1'b1;
          end else begin
            tt_wr.cnt_en = 1'b1;
            tt_wr.cnt    = tt_rd_count - 1'b1;
          end
        end
      end
      S_SW1: begin
        // outgoing thread goes back to ready only if it was running
        tt_rd_idx = cur_idx;
        if (cur_valid && (cur_r != rrts_pkg::CUR_W'(idx_r))
            && (tt_rd_state == rrts_pkg::ST_RUNNING)) begin
          tt_wr.st_en = 1'b1;
        end
      end
      S_SW2: begin
        tt_wr.st_en = 1'b1;
        tt_wr.idx   = idx_r;
        tt_wr.st    = rrts_pkg::ST_RUNNING;
      end
      S_MQ: begin
        tt_wr.st_en = 1'b1;
        tt_wr.idx   = mq_rdata;
      end
      S_SQ: begin
        tt_wr.st_en = (act_r == ACT_SIGNAL);
        tt_wr.idx   = sq_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_r      <= 1'b0;
      cur_r       <= '0;
      mfree_r     <= 1'b1;
      mhead_r     <= '0;
      mtail_r     <= '0;
      mwait_r     <= '0;
      sem_r       <= rrts_pkg::SEM_W'(1);
      shead_r     <= '0;
      stail_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // finished item waits here until the output register is free
      if (done_r && (!out_valid_r || !out_stall)) begin
        done_r      <= 1'b0;
        out_valid_r <= 1'b1;
        out_run_r   <= rrts_pkg::OUT_TID_W'(cur_r);
        out_prev_r  <= rrts_pkg::OUT_TID_W'(prev_r);
        out_sw_r    <= sw_r;
        out_mfree_r <= mfree_r;
        out_sem_r   <= sem_r;
      end
      case (state_r)
        S_IDLE: begin
          if (!done_r) begin
            if (cfg_valid) begin
              sem_r   <= rrts_pkg::SEM_W'(cfg_sem_initial);
              shead_r <= '0;
              stail_r <= '0;
            end else if (in_valid) begin
              act_r   <= in_action;
              ticks_r <= in_sleep_ticks;
              prev_r  <= cur_r;
              sw_r    <= 1'b0;
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          done_r  <= 1'b1;
          case (act_r)
            ACT_CREATE: begin
              if (cur_valid) begin
                cur_r <= cur_r + 1'b1;
              end
            end
            ACT_TICK, ACT_YIELD, ACT_SLEEP: begin
              if (act_r != ACT_SLEEP || one_tick) begin
                done_r <= 1'b0;
                cur_r  <= cur_eff;
                if (act_r == ACT_TICK) begin
                  idx_r   <= '0;
                  state_r <= S_CNT;
                end else begin
                  idx_r   <= rrts_pkg::ring_next(cur_eff[rrts_pkg::TID_W-1:0]);
                  state_r <= S_SCAN;
                end
              end
            end
            ACT_LOCK: begin
              if (mfree_r) begin
                mfree_r <= 1'b0;
              end else if (lock_blocks) begin
                mhead_r <= rrts_pkg::ring_next(mhead_r);
                mwait_r <= mwait_r + 1'b1;
              end
            end
            ACT_UNLOCK: begin
              if (mwait_r != '0) begin
                done_r  <= 1'b0;
                state_r <= S_MQ;
              end else begin
                mfree_r <= 1'b1;
              end
            end
            ACT_SEM_WAIT: begin
              if (sem_r > 0) begin
                sem_r <= sem_r - 1'b1;
              end else if (wait_blocks) begin
                sem_r   <= sem_r - 1'b1;
                shead_r <= rrts_pkg::ring_next(shead_r);
              end
            end
            ACT_SIGNAL, ACT_SWAP: begin
              if (sem_r != rrts_pkg::SEM_TOP) begin
                sem_r <= sem_r + 1'b1;
                // count was negative: a waiter is released
                if (sem_r[rrts_pkg::SEM_W-1]) begin
                  done_r  <= 1'b0;
                  state_r <= S_SQ;
                end
              end
            end
            default: ;
          endcase
        end
        S_CNT: begin
          if (idx_r == rrts_pkg::TID_W'(rrts_pkg::MAX_THREADS - 1)) begin
            idx_r   <= rrts_pkg::ring_next(cur_idx);
            state_r <= S_SCAN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SCAN: begin
          if (tt_rd_state == rrts_pkg::ST_READY) begin
            state_r <= S_SW1;
          end else if (idx_r == cur_idx) begin
            state_r <= S_IDLE;
            done_r  <= 1'b1;
          end else begin
            idx_r <= rrts_pkg::ring_next(idx_r);
          end
        end
        S_SW1: begin
          sw_r    <= (cur_r != rrts_pkg::CUR_W'(idx_r));
          state_r <= S_SW2;
        end
        S_SW2: begin
          cur_r   <= rrts_pkg::CUR_W'(idx_r);
          state_r <= S_IDLE;
          done_r  <= 1'b1;
        end
        S_MQ: begin
          mtail_r <= rrts_pkg::ring_next(mtail_r);
          mwait_r <= mwait_r - 1'b1;
          state_r <= S_IDLE;
          done_r  <= 1'b1;
        end
        S_SQ: begin
          stail_r <= rrts_pkg::ring_next(stail_r);
          if (act_r == ACT_SWAP) begin
            idx_r   <= sq_rdata;
            state_r <= S_SW1;
          end else begin
            state_r <= S_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  rrts_thread_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (tt_rd_idx),
    .rd_state (tt_rd_state),
    .rd_count (tt_rd_count),
    .wr       (tt_wr)
  );

  rrts_ram #(
    .WIDTH (rrts_pkg::TID_W),
    .DEPTH (rrts_pkg::MAX_THREADS)
  ) u_mutex_ring (
    .clk   (clk),
    .we    (mq_we),
    .waddr (mhead_r),
    .wdata (cur_idx),
    .raddr (mtail_r),
    .rdata (mq_rdata)
  );

  rrts_ram #(
    .WIDTH (rrts_pkg::TID_W),
    .DEPTH (rrts_pkg::MAX_THREADS)
  ) u_sem_ring (
    .clk   (clk),
    .we    (sq_we),
    .waddr (shead_r),
    .wdata (cur_idx),
    .raddr (stail_r),
    .rdata (sq_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_running_thread  = out_run_r;
  assign out_previous_thread = out_prev_r;
  assign out_switched        = out_sw_r;
  assign out_mutex_is_free   = out_mfree_r;
  assign out_sem_value       = out_sem_r;

  `ASSERT_NEVER(a_mwait_bound, clk, rst_n,
    mwait_r > rrts_pkg::CNT_W'(rrts_pkg::MAX_THREADS), "mutex waiter count overflow")
  `ASSERT_CLK(a_mfree_empty, clk, rst_n,
    mfree_r |-> (mwait_r == '0), "free mutex with queued waiters")
  `ASSERT_NEVER(a_sem_floor, clk, rst_n,
    sem_r < rrts_pkg::SEM_FLOOR, "semaphore count below ring depth")
  `ASSERT_NEVER(a_cur_bound, clk, rst_n,
    cur_r > rrts_pkg::CUR_W'(rrts_pkg::MAX_THREADS), "current thread out of range")

endmodule

[verif/round_robin_thread_scheduler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_tb
// Self-checking bench for the thread scheduler. A behavioural model of the
// thread table, the mutex and the semaphore predicts the status of every item.
// A checker compares each result with the oldest prediction. Directed tests
// come first, then random traffic under four sender/receiver pressure phases
// with semaphore reloads between them.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_tb;
  import rrts_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_TAIL  = 30;
  localparam int NT          = MAX_THREADS;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE = 4'd0,
    ACT_TICK   = 4'd1,
    ACT_SLEEP  = 4'd2,
    ACT_YIELD  = 4'd3,
    ACT_LOCK   = 4'd4,
    ACT_UNLOCK = 4'd5,
    ACT_WAIT   = 4'd6,
    ACT_SIGNAL = 4'd7,
    ACT_SWAP   = 4'd8
  } act_t;

  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = ACT_SWAP + 1'b1;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = '1;

  typedef struct {
    logic [OUT_TID_W-1:0]    running;
    logic [OUT_TID_W-1:0]    previous;
    logic                    switched;
    logic                    mutex_free;
    logic signed [SEM_W-1:0] sem;
  } status_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [ACT_W-1:0]         in_action;
  logic [TICK_W-1:0]        in_sleep_ticks;
  logic                     out_valid;
  logic                     out_stall;
  logic [OUT_TID_W-1:0]     out_running_thread;
  logic [OUT_TID_W-1:0]     out_previous_thread;
  logic                     out_switched;
  logic                     out_mutex_is_free;
  logic signed [SEM_W-1:0]  out_sem_value;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_sem_initial;

  round_robin_thread_scheduler u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_sleep_ticks      (in_sleep_ticks),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_running_thread  (out_running_thread),
    .out_previous_thread (out_previous_thread),
    .out_switched        (out_switched),
    .out_mutex_is_free   (out_mutex_is_free),
    .out_sem_value       (out_sem_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_sem_initial     (cfg_sem_initial)
  );

  // scheduler model state
  tstate_t           thr_st    [NT];
  logic [TICK_W-1:0] thr_sleep [NT];
  int                cur_tid;
  bit                mtx_free;
  int                mtx_ring  [NT];
  int                mtx_wr;
  int                mtx_rd;
  int                mtx_waiters;
  int                sem_cnt;
  int                sem_ring  [NT];
  int                sem_wr;
  int                sem_rd;

  status_t status_q[$];
  status_t head_status;

  int  idle_pct;
  int  stall_pct;
  int  err_cnt;
  int  item_cnt;
  int  result_cnt;
  int  cfg_cnt;
  int  cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int wrap_inc(int p);
    return (p + 1) % NT;
  endfunction

  // make thread nt running; outgoing thread only drops to ready if it ran
  function automatic bit hand_over(int nt);
    bit changed;
    changed = (nt != cur_tid);
    if (changed && cur_tid < NT && thr_st[cur_tid] == ST_RUNNING) thr_st[cur_tid] = ST_READY;
    thr_st[nt] = ST_RUNNING;
    cur_tid    = nt;
    return changed;
  endfunction

  function automatic bit pick_next(bit countdown);
    int start;
    int idx;
    if (cur_tid >= NT) cur_tid = 0;
    if (countdown) begin
      for (int k = 0; k < NT; k++) begin
        if (thr_st[k] == ST_SLEEPING) begin
          if (thr_sleep[k] == '0) thr_st[k] = ST_READY;
          else thr_sleep[k] = thr_sleep[k] - 1'b1;
        end
      end
    end
    start = cur_tid;
    idx   = start;
    // scan wraps round and ends on the current thread itself
    repeat (NT) begin
      idx = wrap_inc(idx);
      if (thr_st[idx] == ST_READY) return hand_over(idx);
    end
    return 1'b0;
  endfunction

  function automatic void model_reset();
    for (int k = 0; k < NT; k++) begin
      thr_st[k]    = ST_ABSENT;
      thr_sleep[k] = '0;
    end
    cur_tid     = 0;
    mtx_free    = 1'b1;
    mtx_wr      = 0;
    mtx_rd      = 0;
    mtx_waiters = 0;
    sem_cnt     = 1;
    sem_wr      = 0;
    sem_rd      = 0;
  endfunction

  function automatic status_t compute_status(logic [ACT_W-1:0] act, logic [TICK_W-1:0] ticks);
    status_t st;
    int      prev;
    bit      sw;
    int      tid;
    prev = cur_tid;
    sw   = 1'b0;
    case (act)
      ACT_CREATE: begin
        if (cur_tid < NT) begin
          thr_st[cur_tid] = ST_READY;
          cur_tid++;
        end
      end
      ACT_TICK: sw = pick_next(1'b1);
      ACT_SLEEP: begin
        if (ticks == TICK_W'(1)) begin
          sw = pick_next(1'b0);
        end else if (cur_tid < NT) begin
          thr_st[cur_tid]    = ST_SLEEPING;
          thr_sleep[cur_tid] = ticks;
        end
      end
      ACT_YIELD: sw = pick_next(1'b0);
      ACT_LOCK: begin
        if (mtx_free) begin
          mtx_free = 1'b0;
        end else if (cur_tid < NT && mtx_waiters < NT) begin
          mtx_ring[mtx_wr] = cur_tid;
          thr_st[cur_tid]  = ST_WAITING;
          mtx_wr           = wrap_inc(mtx_wr);
          mtx_waiters++;
        end
      end
      ACT_UNLOCK: begin
        mtx_free = 1'b1;
        if (mtx_waiters > 0) begin
          thr_st[mtx_ring[mtx_rd]] = ST_READY;
          mtx_rd   = wrap_inc(mtx_rd);
          mtx_waiters--;
          mtx_free = 1'b0;
        end
      end
      ACT_WAIT: begin
        if (sem_cnt > 0) begin
          sem_cnt--;
        end else if (cur_tid < NT && sem_cnt > int'(SEM_FLOOR)) begin
          sem_cnt--;
          sem_ring[sem_wr] = cur_tid;
          thr_st[cur_tid]  = ST_WAITING;
          sem_wr           = wrap_inc(sem_wr);
        end
      end
      ACT_SIGNAL, ACT_SWAP: begin
        if (sem_cnt < int'(SEM_TOP)) begin
          sem_cnt++;
          if (sem_cnt <= 0) begin
            tid    = sem_ring[sem_rd];
            sem_rd = wrap_inc(sem_rd);
            if (act == ACT_SIGNAL) thr_st[tid] = ST_READY;
            else sw = hand_over(tid);
          end
        end
      end
      default: ;
    endcase
    st.running    = OUT_TID_W'(cur_tid);
    st.previous   = OUT_TID_W'(prev);
    st.switched   = sw;
    st.mutex_free = mtx_free;
    st.sem        = SEM_W'(sem_cnt);
    return st;
  endfunction

  task automatic send_item(logic [ACT_W-1:0] act, logic [TICK_W-1:0] ticks);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid       <= 1'b0;
      in_action      <= ACT_W'($urandom);
      in_sleep_ticks <= TICK_W'($urandom);
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_sleep_ticks <= ticks;
    do @(posedge clk); while (in_stall);
    status_q.push_back(compute_status(act, ticks));
    item_cnt++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (status_q.size() != 0) @(posedge clk);
  endtask

  // reload takes effect only with the block idle
  task automatic cfg_write(int value);
    go_idle();
    wait_drained();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_sem_initial <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    sem_cnt = value;
    sem_wr  = 0;
    sem_rd  = 0;
    cfg_cnt++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic cmp_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_cnt++;
      if (status_q.size() == 0) begin
        $display("%0t: result with nothing expected, running %0d previous %0d",
                 $time, out_running_thread, out_previous_thread);
        err_cnt++;
      end else begin
        head_status = status_q.pop_front();
        cmp_field("running_thread", head_status.running, out_running_thread);
        cmp_field("previous_thread", head_status.previous, out_previous_thread);
        cmp_field("switched", head_status.switched, out_switched);
        cmp_field("mutex_is_free", head_status.mutex_free, out_mutex_is_free);
        cmp_field("sem_value", int'(head_status.sem), int'(out_sem_value));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // tick and unused code on an empty table, fill every slot, then poke the block with no valid current thread
  task automatic test_create_and_empty_tick();
    send_item(ACT_TICK, 16'h0000);
    send_item(ACT_UNUSED_HI, 16'hFFFF);
    repeat (NT) send_item(ACT_CREATE, 16'h0000);
    send_item(ACT_CREATE, 16'h5A5A);
    send_item(ACT_SLEEP, 16'h1234);
  endtask

  task automatic test_sync_without_thread();
    send_item(ACT_LOCK, 16'h0000);
    send_item(ACT_LOCK, 16'h0000);
    send_item(ACT_WAIT, 16'h0000);
    send_item(ACT_WAIT, 16'h0000);
  endtask

  task automatic test_scheduling();
    send_item(ACT_TICK, 16'h0000);
    send_item(ACT_YIELD, 16'h0000);
    send_item(ACT_SLEEP, 16'h0001);
    send_item(ACT_SLEEP, 16'h0000);
    send_item(ACT_SLEEP, 16'hFFFF);
    send_item(ACT_TICK, 16'h0000);
  endtask

  task automatic test_sync_handover();
    send_item(ACT_UNLOCK, 16'h0000);
    send_item(ACT_WAIT, 16'h0000);
    send_item(ACT_SIGNAL, 16'h0000);
    send_item(ACT_WAIT, 16'h0000);
    send_item(ACT_SWAP, 16'h0000);
    cfg_write(int'(SEM_TOP));
    send_item(ACT_SIGNAL, 16'h0000);
    send_item(ACT_SWAP, 16'h0000);
    cfg_write(0);
  endtask

  task automatic test_random_traffic(int n_items, int idle, int stall);
    int               sent;
    int               r;
    int               burst;
    logic [ACT_W-1:0] act;
    logic [TICK_W-1:0] ticks;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < n_items) begin
      r     = $urandom_range(99);
      ticks = TICK_W'($urandom);
      if      (r < 5)  act = ACT_CREATE;
      else if (r < 30) act = ACT_TICK;
      else if (r < 40) act = ACT_SLEEP;
      else if (r < 48) act = ACT_YIELD;
      else if (r < 58) act = ACT_LOCK;
      else if (r < 68) act = ACT_UNLOCK;
      else if (r < 78) act = ACT_WAIT;
      else if (r < 88) act = ACT_SIGNAL;
      else if (r < 95) act = ACT_SWAP;
      else             act = ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      if (act == ACT_SLEEP) begin
        // mostly short sleeps so most sleepers come back within the run
        r = $urandom_range(99);
        if      (r < 15) ticks = TICK_W'(1);
        else if (r < 85) ticks = TICK_W'($urandom_range(6));
        else if (r < 95) ticks = TICK_W'($urandom_range(60));
      end
      // runs of one sync action fill the wait rings or drain them
      burst = 1;
      if ((act == ACT_LOCK || act == ACT_WAIT || act == ACT_SIGNAL) &&
          $urandom_range(99) < 8)
        burst = $urandom_range(10, 6);
      repeat (burst) begin
        send_item(act, ticks);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = '0;
    in_sleep_ticks  = '0;
    cfg_valid       = 1'b0;
    cfg_sem_initial = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    err_cnt         = 0;
    item_cnt        = 0;
    result_cnt      = 0;
    cfg_cnt         = 0;
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_create_and_empty_tick();
    test_sync_without_thread();
    test_scheduling();
    test_sync_handover();

    cfg_write(3);
    test_random_traffic(355, 0, 0);
    cfg_write(0);
    test_random_traffic(355, 83, 0);
    cfg_write(int'(SEM_TOP));
    test_random_traffic(355, 0, 83);
    cfg_write($urandom_range(126, 1));
    test_random_traffic(355, 13, 13);

    go_idle();
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Run covered %0d items and %0d results over four pressure phases,",
             item_cnt, result_cnt);
    $display("with %0d semaphore reloads including both ends of the range.", cfg_cnt);
    if (err_cnt == 0 && status_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rrts_pkg.sv
rtl/rrts_ram.sv
rtl/rrts_thread_table.sv
rtl/round_robin_thread_scheduler.sv
verif/round_robin_thread_scheduler_tb.sv
